// ----- sv/pfc_pkg.sv -----
// Package for the packet frame checker: result item type, status and kind codes,
// header constants and the byte-wide reflected CRC-32 update.
// No dependencies.
package pfc_pkg;

  localparam logic [31:0] MAGIC_VALUE  = 32'hA1C9F00D;
  localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [31:0] HEADER_BYTES = 32'd16;
  localparam int          QUEUE_DEPTH  = 4;
  localparam int          QUEUE_AW     = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNCATED = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_LEN_ERR   = 3'd3,
    ST_CRC_ERR   = 3'd4
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    status_t     status;
    logic [15:0] packet_version;
    logic [31:0] payload_size;
    logic        end_of_packet;
  } result_t;

  typedef struct packed {
    logic    pay_valid;
    logic    stat_valid;
    result_t pay;
    result_t stat;
  } push_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/pfc_in_if.sv -----
// Input channel of the packet frame checker: one packet byte per item.
// Depends on nothing.
interface pfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- sv/pfc_out_if.sv -----
// Result channel of the packet frame checker: payload bytes and end-of-packet status.
// Depends on nothing.
interface pfc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [2:0]  status;
  logic [15:0] packet_version;
  logic [31:0] payload_size;
  logic        end_of_packet;

  modport source (output valid, output kind, output payload_byte, output status,
                  output packet_version, output payload_size, output end_of_packet,
                  input ready);
  modport sink (input valid, input kind, input payload_byte, input status,
                input packet_version, input payload_size, input end_of_packet,
                output ready);
endinterface

// ----- sv/pfc_core.sv -----
// Header capture, payload forwarding, CRC-32 and status decision for one byte item.
// Depends on pfc_pkg.
module pfc_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     data_byte,
  input  logic           last_byte,
  output pfc_pkg::push_t push
);

  logic [31:0] bytes_seen, bytes_seen_next;
  logic [31:0] magic_word, magic_word_next;
  logic [15:0] version_word, version_word_next;
  logic [15:0] extra_header_len, extra_header_len_next;
  logic [31:0] payload_len, payload_len_next;
  logic [31:0] expected_crc, expected_crc_next;
  logic [31:0] running_crc, running_crc_next;
  logic [33:0] need_sum;

  logic            in_header;
  logic            saturated;
  logic            in_payload;
  logic [31:0]     payload_offs;
  pfc_pkg::status_t st;

  always_comb begin
    magic_word_next       = magic_word;
    version_word_next     = version_word;
    extra_header_len_next = extra_header_len;
    payload_len_next      = payload_len;
    expected_crc_next     = expected_crc;
    running_crc_next      = running_crc;

    in_header    = (bytes_seen[31:4] == 28'd0);
    saturated    = &bytes_seen;
    payload_offs = bytes_seen - pfc_pkg::HEADER_BYTES;
    in_payload   = !in_header && !saturated && (payload_offs < payload_len);

    if (in_header) begin
      case (bytes_seen[3:2])
        2'd0: magic_word_next[{bytes_seen[1:0], 3'b000} +: 8] = data_byte;
        2'd1: begin
          if (!bytes_seen[1]) begin
            version_word_next[{bytes_seen[0], 3'b000} +: 8] = data_byte;
          end else begin
            extra_header_len_next[{bytes_seen[0], 3'b000} +: 8] = data_byte;
          end
        end
        2'd2: payload_len_next[{bytes_seen[1:0], 3'b000} +: 8] = data_byte;
        default: expected_crc_next[{bytes_seen[1:0], 3'b000} +: 8] = data_byte;
      endcase
    end else if (in_payload) begin
      running_crc_next = pfc_pkg::crc_byte(running_crc, data_byte);
    end

    bytes_seen_next = saturated ? bytes_seen : bytes_seen + 32'd1;

    if (bytes_seen_next < pfc_pkg::HEADER_BYTES) begin
      st = pfc_pkg::ST_TRUNCATED;
    end else if (magic_word_next != pfc_pkg::MAGIC_VALUE) begin
      st = pfc_pkg::ST_BAD_MAGIC;
    end else if (need_sum > {2'b00, bytes_seen_next}) begin
      st = pfc_pkg::ST_LEN_ERR;
    end else if (~running_crc_next != expected_crc_next) begin
      st = pfc_pkg::ST_CRC_ERR;
    end else begin
      st = pfc_pkg::ST_OK;
    end

    push.pay_valid                = accept && in_payload;
    push.pay.kind                 = pfc_pkg::KIND_PAYLOAD;
    push.pay.payload_byte         = data_byte;
    push.pay.status               = pfc_pkg::ST_OK;
    push.pay.packet_version       = 16'd0;
    push.pay.payload_size         = 32'd0;
    push.pay.end_of_packet        = 1'b0;

    push.stat_valid               = accept && last_byte;
    push.stat.kind                = pfc_pkg::KIND_STATUS;
    push.stat.payload_byte        = 8'd0;
    push.stat.status              = st;
    push.stat.packet_version      = version_word_next;
    push.stat.payload_size        = payload_len_next;
    push.stat.end_of_packet       = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen       <= '0;
      magic_word       <= '0;
      version_word     <= '0;
      extra_header_len <= '0;
      payload_len      <= '0;
      expected_crc     <= '0;
      running_crc      <= '1;
      need_sum         <= {2'b00, pfc_pkg::HEADER_BYTES};
    end else begin
      need_sum <= {2'b00, payload_len} + {18'd0, extra_header_len}
                  + {2'b00, pfc_pkg::HEADER_BYTES};
      if (accept) begin
        if (last_byte) begin
          bytes_seen       <= '0;
          magic_word       <= '0;
          version_word     <= '0;
          extra_header_len <= '0;
          payload_len      <= '0;
          expected_crc     <= '0;
          running_crc      <= '1;
        end else begin
          bytes_seen       <= bytes_seen_next;
          magic_word       <= magic_word_next;
          version_word     <= version_word_next;
          extra_header_len <= extra_header_len_next;
          payload_len      <= payload_len_next;
          expected_crc     <= expected_crc_next;
          running_crc      <= running_crc_next;
        end
      end
    end
  end

endmodule

// ----- sv/pfc_queue.sv -----
// Result queue: takes up to two result items per cycle, hands out one per handshake.
// Depends on pfc_pkg.
module pfc_queue (
  input  logic             clk,
  input  logic             rst,
  input  pfc_pkg::push_t   push,
  output logic             space,
  output logic             head_valid,
  output pfc_pkg::result_t head,
  input  logic             pop
);

  localparam int AW = pfc_pkg::QUEUE_AW;

  pfc_pkg::result_t mem [pfc_pkg::QUEUE_DEPTH];
  logic [AW-1:0]    rd_ptr;
  logic [AW-1:0]    wr_ptr;
  logic [AW:0]      count;
  logic [AW:0]      n_push;
  logic             do_pop;
  pfc_pkg::result_t first;

  always_comb begin
    head_valid = (count != '0);
    head       = mem[rd_ptr];
    space      = (count <= (AW + 1)'(pfc_pkg::QUEUE_DEPTH - 2));
    do_pop     = pop && head_valid;
    n_push     = (AW + 1)'(push.pay_valid) + (AW + 1)'(push.stat_valid);
    first      = push.pay_valid ? push.pay : push.stat;
  end

  always_ff @(posedge clk) begin
    if (n_push != '0) begin
      mem[wr_ptr] <= first;
    end
    if (push.pay_valid && push.stat_valid) begin
      mem[wr_ptr + AW'(1)] <= push.stat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[AW-1:0];
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + n_push - (AW + 1)'(do_pop);
    end
  end

endmodule

// ----- sv/packet_frame_checker_top.sv -----
// Packet frame checker top level: byte items in, payload and status items out.
// Results: each result item is registered in the result queue when its byte item is accepted.
// Throughput: one byte item per cycle; the four-entry result queue sets ready.
// Reset: synchronous rst clears the header fields, byte counter, CRC and queue.
// Depends on pfc_pkg, pfc_in_if, pfc_out_if, pfc_core and pfc_queue.
module packet_frame_checker_top (
  input logic      clk,
  input logic      rst,
  pfc_in_if.sink   packet,
  pfc_out_if.source result
);

  logic             accept;
  logic             space;
  logic             head_valid;
  pfc_pkg::push_t   push;
  pfc_pkg::result_t head;

  assign packet.ready = space;
  assign accept       = packet.valid && space;

  pfc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (packet.data_byte),
    .last_byte (packet.last_byte),
    .push      (push)
  );

  pfc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .space      (space),
    .head_valid (head_valid),
    .head       (head),
    .pop        (result.ready)
  );

  assign result.valid          = head_valid;
  assign result.kind           = head.kind;
  assign result.payload_byte   = head.payload_byte;
  assign result.status         = head.status;
  assign result.packet_version = head.packet_version;
  assign result.payload_size   = head.payload_size;
  assign result.end_of_packet  = head.end_of_packet;

  a_stat_on_last: assert property (@(posedge clk) disable iff (rst)
    push.stat_valid |-> (packet.valid && packet.ready && packet.last_byte))
    else $error("status item without an accepted last byte");

  a_pay_byte: assert property (@(posedge clk) disable iff (rst)
    push.pay_valid |-> (accept && push.pay.payload_byte == packet.data_byte))
    else $error("forwarded byte differs from accepted item");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    (push.pay_valid || push.stat_valid) |-> space)
    else $error("result pushed without queue space");

endmodule

// ----- tb/tb_packet_frame_checker_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for packet_frame_checker_top: byte items in, payload and status out.
// Predicts every result item from its own deframer model and compares each field.
// Depends on pfc_pkg, pfc_in_if, pfc_out_if and the packet_frame_checker_top RTL.
module tb_packet_frame_checker_top;

  localparam int ITEM_TARGET    = 1800;
  localparam int TAIL_ITEMS     = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int LONG_HOLD      = 400;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic clk;
  logic rst;

  pfc_in_if  packet ();
  pfc_out_if result ();

  packet_frame_checker_top dut (
    .clk    (clk),
    .rst    (rst),
    .packet (packet.sink),
    .result (result.source)
  );

  frame_byte_t      stimulus_q[$];
  pfc_pkg::result_t expected_results[$];
  int               stimulus_total;
  int               bytes_accepted;
  int               results_seen;
  int               error_count;
  int               idle_cycles;
  logic             tail_phase;

  // deframer prediction state
  logic [31:0] rx_count;
  logic [31:0] rx_magic;
  logic [15:0] rx_version;
  logic [15:0] rx_extra;
  logic [31:0] rx_plen;
  logic [31:0] rx_crc_field;
  logic [31:0] rx_crc;

  int          src_gap;
  int          src_phase_left;
  logic        src_idle_on;
  frame_byte_t next_byte;

  int               snk_gap;
  int               snk_hold;
  int               snk_phase_left;
  logic             snk_idle_on;
  logic             hold_done;
  pfc_pkg::result_t want;

  function automatic logic [31:0] crc32_next(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ pfc_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic clear_frame();
    rx_count     = '0;
    rx_magic     = '0;
    rx_version   = '0;
    rx_extra     = '0;
    rx_plen      = '0;
    rx_crc_field = '0;
    rx_crc       = '1;
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic last);
    pfc_pkg::result_t r;
    pfc_pkg::status_t st;
    logic [31:0]      pos;
    logic [33:0]      need;
    pos = rx_count;
    if (pos < 4) begin
      rx_magic[pos[1:0]*8 +: 8] = b;
    end else if (pos < 6) begin
      rx_version[pos[0]*8 +: 8] = b;
    end else if (pos < 8) begin
      rx_extra[pos[0]*8 +: 8] = b;
    end else if (pos < 12) begin
      rx_plen[pos[1:0]*8 +: 8] = b;
    end else if (pos < pfc_pkg::HEADER_BYTES) begin
      rx_crc_field[pos[1:0]*8 +: 8] = b;
    end else if (pos != '1 && (pos - pfc_pkg::HEADER_BYTES) < rx_plen) begin
      rx_crc = crc32_next(rx_crc, b);
      r = '0;
      r.kind = pfc_pkg::KIND_PAYLOAD;
      r.payload_byte = b;
      r.status = pfc_pkg::ST_OK;
      expected_results.push_back(r);
    end
    if (pos != '1) begin
      rx_count = pos + 32'd1;
    end
    if (last) begin
      need = {2'b0, rx_plen} + {18'b0, rx_extra} + {2'b0, pfc_pkg::HEADER_BYTES};
      if (rx_count < pfc_pkg::HEADER_BYTES) begin
        st = pfc_pkg::ST_TRUNCATED;
      end else if (rx_magic != pfc_pkg::MAGIC_VALUE) begin
        st = pfc_pkg::ST_BAD_MAGIC;
      end else if (need > {2'b0, rx_count}) begin
        st = pfc_pkg::ST_LEN_ERR;
      end else if (~rx_crc != rx_crc_field) begin
        st = pfc_pkg::ST_CRC_ERR;
      end else begin
        st = pfc_pkg::ST_OK;
      end
      r = '0;
      r.kind = pfc_pkg::KIND_STATUS;
      r.status = st;
      r.packet_version = rx_version;
      r.payload_size = rx_plen;
      r.end_of_packet = 1'b1;
      expected_results.push_back(r);
      clear_frame();
    end
  endtask

  task automatic queue_frame(input logic [31:0] magic, input logic [15:0] ver,
                             input logic [15:0] extra, input logic [31:0] plen,
                             input int body, input int tail, input logic [31:0] crc_flip,
                             input int cut);
    logic [127:0] hdr;
    logic [31:0]  crc;
    logic [7:0]   bytes[$];
    logic [7:0]   b;
    int           n;
    crc = '1;
    for (int i = 0; i < body; i++) begin
      b = 8'($urandom);
      bytes.push_back(b);
      crc = crc32_next(crc, b);
    end
    hdr = {~crc ^ crc_flip, plen, extra, ver, magic};
    for (int i = 15; i >= 0; i--) begin
      bytes.push_front(hdr[i*8 +: 8]);
    end
    for (int i = 0; i < tail; i++) begin
      bytes.push_back(8'($urandom));
    end
    n = (cut > 0 && cut < bytes.size()) ? cut : bytes.size();
    for (int i = 0; i < n; i++) begin
      stimulus_q.push_back('{data: bytes[i], last: (i == n - 1)});
    end
  endtask

  function automatic void compare_field(input string field, input logic [31:0] exp_val,
                                        input logic [31:0] got);
    if (exp_val !== got) begin
      $error("%s mismatch: expected %0h, got %0h", field, exp_val, got);
      error_count++;
    end
  endfunction

  always #5 clk = ~clk;

  // byte driver and prediction at acceptance
  always @(posedge clk) begin
    if (rst) begin
      packet.valid <= 1'b0;
      src_gap = 0;
      src_phase_left = 0;
      src_idle_on = 1'b0;
    end else begin
      if (packet.valid && packet.ready) begin
        deframe_byte(packet.data_byte, packet.last_byte);
        bytes_accepted++;
      end
      tail_phase <= (stimulus_q.size() < TAIL_ITEMS);
      if (src_phase_left == 0) begin
        src_phase_left = $urandom_range(50, 300);
        src_idle_on = ($urandom_range(0, 2) != 0);
      end else begin
        src_phase_left--;
      end
      if (!packet.valid || packet.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          packet.valid <= 1'b0;
        end else if (stimulus_q.size() == 0) begin
          packet.valid <= 1'b0;
        end else if (!tail_phase && src_idle_on && $urandom_range(0, 3) == 0) begin
          src_gap = $urandom_range(0, 18);
          packet.valid <= 1'b0;
        end else begin
          next_byte = stimulus_q.pop_front();
          packet.valid <= 1'b1;
          packet.data_byte <= next_byte.data;
          packet.last_byte <= next_byte.last;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      snk_gap = 0;
      snk_hold = 0;
      snk_phase_left = 0;
      snk_idle_on = 1'b0;
      hold_done = 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result item: kind %0h status %0h", result.kind, result.status);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("kind", 32'(want.kind), 32'(result.kind));
          compare_field("payload_byte", 32'(want.payload_byte), 32'(result.payload_byte));
          compare_field("status", 32'(want.status), 32'(result.status));
          compare_field("packet_version", 32'(want.packet_version),
                        32'(result.packet_version));
          compare_field("payload_size", want.payload_size, result.payload_size);
          compare_field("end_of_packet", 32'(want.end_of_packet), 32'(result.end_of_packet));
        end
      end
      if (snk_phase_left == 0) begin
        snk_phase_left = $urandom_range(50, 300);
        snk_idle_on = ($urandom_range(0, 2) != 0);
      end else begin
        snk_phase_left--;
      end
      if (snk_hold > 0) begin
        snk_hold--;
        result.ready <= 1'b0;
      end else if (!hold_done && results_seen >= 200) begin
        hold_done = 1'b1;
        snk_hold = LONG_HOLD - 1;
        result.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        result.ready <= 1'b0;
      end else if (!tail_phase && snk_idle_on && $urandom_range(0, 3) == 0) begin
        snk_gap = $urandom_range(0, 18);
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((packet.valid && packet.ready) || (result.valid && result.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          pick;
    int          cut;
    logic [15:0] ver;
    logic [15:0] extra;
    logic [31:0] plen;
    logic        timed_out;

    clk = 1'b0;
    rst = 1'b1;
    packet.valid = 1'b0;
    packet.data_byte = '0;
    packet.last_byte = 1'b0;
    result.ready = 1'b0;
    tail_phase = 1'b0;
    idle_cycles = 0;
    bytes_accepted = 0;
    results_seen = 0;
    error_count = 0;
    timed_out = 1'b0;
    clear_frame();

    // one-byte packet, header-only packet with empty payload, packet cut inside the header
    stimulus_q.push_back('{data: 8'hFF, last: 1'b1});
    queue_frame(pfc_pkg::MAGIC_VALUE, 16'hFFFF, 16'h0000, 32'h0, 0, 0, 32'h0, 0);
    queue_frame(pfc_pkg::MAGIC_VALUE, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 0, 0, 32'h0, 8);

    while (stimulus_q.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 7))
        0:       ver = 16'h0000;
        1:       ver = 16'hFFFF;
        default: ver = 16'($urandom);
      endcase
      extra = 16'($urandom_range(0, 4));
      plen = ($urandom_range(0, 5) == 0) ? 32'h0 : 32'($urandom_range(1, 24));
      if (pick < 55) begin
        queue_frame(pfc_pkg::MAGIC_VALUE, ver, extra, plen, int'(plen),
                    int'(extra) + $urandom_range(0, 3), 32'h0, 0);
      end else if (pick < 65) begin
        queue_frame(pfc_pkg::MAGIC_VALUE, ver, extra, plen, int'(plen),
                    int'(extra) + $urandom_range(0, 3), 32'h1 << $urandom_range(0, 31), 0);
      end else if (pick < 73) begin
        queue_frame(pfc_pkg::MAGIC_VALUE ^ (32'h1 << $urandom_range(0, 31)), ver, extra, plen,
                    int'(plen), int'(extra), 32'h0, 0);
      end else if (pick < 81) begin
        cut = (plen + extra > 0) ? $urandom_range(16, 15 + plen + extra) : 0;
        queue_frame(pfc_pkg::MAGIC_VALUE, ver, extra, plen, int'(plen), int'(extra), 32'h0,
                    cut);
      end else if (pick < 87) begin
        queue_frame(pfc_pkg::MAGIC_VALUE, ver, extra, plen, int'(plen), 0, 32'h0,
                    $urandom_range(1, 15));
      end else if (pick < 93) begin
        extra = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
        plen = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'($urandom);
        queue_frame(pfc_pkg::MAGIC_VALUE, ver, extra, plen, $urandom_range(0, 20), 0, 32'h0,
                    0);
      end else begin
        queue_frame($urandom, 16'($urandom), 16'($urandom), $urandom, 0,
                    $urandom_range(0, 24), $urandom, $urandom_range(1, 40));
      end
    end
    stimulus_total = stimulus_q.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (!(bytes_accepted == stimulus_total && expected_results.size() == 0) &&
           idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
    end
    timed_out = (idle_cycles >= WATCHDOG_LIMIT);
    if (!timed_out) begin
      repeat (DRAIN_CYCLES) @(posedge clk);
    end
    if (!timed_out && error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/pfc_pkg.sv
sv/pfc_in_if.sv
sv/pfc_out_if.sv
sv/pfc_core.sv
sv/pfc_queue.sv
sv/packet_frame_checker_top.sv
tb/tb_packet_frame_checker_top.sv
